// ----- sv/adc_value_ascii_formatter_defines.svh -----
// assertion macros used by the checker file
`ifndef ADC_VALUE_ASCII_FORMATTER_DEFINES_SVH
`define ADC_VALUE_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define AVAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define AVAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/avaf_pkg.sv -----
package avaf_pkg;

  typedef enum logic [1:0] {
    OP_HEX  = 2'd0,
    OP_DEC  = 2'd1,
    OP_BIN  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  localparam int unsigned VALUE_W = 10;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned IDX_W   = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA_A = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_NINE    = 7'h39;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA_F = 7'h46;
  localparam logic [CHAR_W-1:0] HEX_ALPHA_OFS = 7'd7;

  // index of the trailing space in each run
  localparam logic [IDX_W-1:0] HEX_LAST_IDX = 4'd3;
  localparam logic [IDX_W-1:0] DEC_LAST_IDX = 4'd4;
  localparam logic [IDX_W-1:0] BIN_LAST_IDX = 4'd12;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    c = ASCII_ZERO + {3'b000, nib};
    if (nib >= 4'hA) begin
      c = c + HEX_ALPHA_OFS;
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] dec_char(input logic [3:0] dig);
    return ASCII_ZERO + {3'b000, dig};
  endfunction

  function automatic logic [IDX_W-1:0] last_idx(input op_e op);
    logic [IDX_W-1:0] r;
    case (op)
      OP_HEX:  r = HEX_LAST_IDX;
      OP_DEC:  r = DEC_LAST_IDX;
      OP_BIN:  r = BIN_LAST_IDX;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/adc_value_ascii_formatter.sv -----
// channel   | dir | tdata                      | tuser / tlast
// ----------+-----+----------------------------+-----------------------------
// s_axis    | in  | [9:0] value, [15:10] zero  | tuser [1:0] op (radix select)
// m_axis    | out | [6:0] ascii_char, [7] zero | tlast = last (trailing space)
//
// one character per cycle leaves the output register unless m_axis stalls;
// a value yields 4 (hex), 5 (decimal) or 13 (binary) characters, set by the
// character counter, and an unused selector is taken and emits nothing
// the next value is taken in the cycle the last character of the current run
// moves into the output register, so runs follow each other without a gap
// a stall on m_axis holds the output register and the counter; rst_ni clears
// the holding and output valid flags at once
module adc_value_ascii_formatter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [9:0] value, [15:10] unused
  input  logic [1:0] s_axis_tuser_i,   // [1:0] op
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] ascii_char, [7] zero
  output logic       m_axis_tlast_o
);

  localparam int unsigned VW = avaf_pkg::VALUE_W;
  localparam int unsigned CW = avaf_pkg::CHAR_W;
  localparam int unsigned IW = avaf_pkg::IDX_W;

  // holding register: the value being spelled out plus its decimal split
  logic              hold_vld_q, hold_vld_d;
  avaf_pkg::op_e     op_q, op_d;
  logic [VW-1:0]     value_q, value_d;
  logic              thou_q, thou_d;      // value > 999
  logic [3:0]        hund_q, hund_d;      // hundreds digit
  logic [6:0]        rem_q, rem_d;        // value mod 100
  logic [IW-1:0]     idx_q, idx_d;        // character position in the run

  // output register
  logic              out_vld_q, out_vld_d;
  logic [CW-1:0]     out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic              s_acc;
  logic              out_free;
  logic              advance;
  logic              run_end;
  logic [CW-1:0]     cur_char;
  logic              cur_last;

  // decimal split at intake: subtract one thousand from a value above 999,
  // then divide by 100 by multiplying with 41/4096 (exact below 1000)
  logic [VW-1:0]     in_value;
  logic [VW-1:0]     in_below;
  logic [15:0]       hund_prod;
  logic [3:0]        in_hund;
  logic [VW-1:0]     in_rem;

  assign in_value = s_axis_tdata_i[VW-1:0];

  always_comb begin
    in_below  = (in_value > 10'd999) ? (in_value - 10'd1000) : in_value;
    hund_prod = {6'b0, in_below} * 16'd41;
    in_hund   = hund_prod[15:12];
    in_rem    = in_below - ({6'b0, in_hund} * 10'd100);
  end

  // character generation for the current position
  logic [14:0]       tens_prod;
  logic [3:0]        tens;
  logic [6:0]        ones_full;
  logic [3:0]        ones;
  logic [11:0]       bin_word;
  logic [IW-1:0]     bit_sel;

  always_comb begin
    tens_prod = {8'b0, rem_q} * 15'd205;   // divide by ten, exact below 1029
    tens      = tens_prod[14:11];
    ones_full = rem_q - ({3'b000, tens} * 7'd10);
    ones      = ones_full[3:0];
    bin_word  = {2'b00, value_q};
    bit_sel   = 4'd11 - idx_q;
    cur_char  = avaf_pkg::ASCII_SPACE;
    cur_last  = (idx_q == avaf_pkg::last_idx(op_q));
    case (op_q)
      avaf_pkg::OP_HEX: begin
        case (idx_q)
          4'd0:    cur_char = avaf_pkg::hex_char({2'b00, value_q[9:8]});
          4'd1:    cur_char = avaf_pkg::hex_char(value_q[7:4]);
          4'd2:    cur_char = avaf_pkg::hex_char(value_q[3:0]);
          default: cur_char = avaf_pkg::ASCII_SPACE;
        endcase
      end
      avaf_pkg::OP_DEC: begin
        // leading positions stay blank until the first shown digit
        case (idx_q)
          4'd0: begin
            if (thou_q) begin
              cur_char = avaf_pkg::dec_char(4'd1);
            end
          end
          4'd1: begin
            if (value_q > 10'd99) begin
              cur_char = avaf_pkg::dec_char(hund_q);
            end
          end
          4'd2: begin
            if (value_q > 10'd9) begin
              cur_char = avaf_pkg::dec_char(tens);
            end
          end
          4'd3:    cur_char = avaf_pkg::dec_char(ones);
          default: cur_char = avaf_pkg::ASCII_SPACE;
        endcase
      end
      avaf_pkg::OP_BIN: begin
        // msb first, the two top positions are always zero
        if (idx_q < avaf_pkg::BIN_LAST_IDX) begin
          cur_char = avaf_pkg::dec_char({3'b000, bin_word[bit_sel]});
        end
      end
      default: cur_char = avaf_pkg::ASCII_SPACE;
    endcase
  end

  // handshake
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = hold_vld_q && out_free;
  assign run_end         = advance && cur_last;
  assign s_axis_tready_o = !hold_vld_q || run_end;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    hold_vld_d = hold_vld_q;
    op_d       = op_q;
    value_d    = value_q;
    thou_d     = thou_q;
    hund_d     = hund_q;
    rem_d      = rem_q;
    idx_d      = idx_q;
    if (s_acc) begin
      // an unused selector is taken and dropped
      hold_vld_d = (avaf_pkg::op_e'(s_axis_tuser_i) != avaf_pkg::OP_NONE);
      op_d       = avaf_pkg::op_e'(s_axis_tuser_i);
      value_d    = in_value;
      thou_d     = (in_value > 10'd999);
      hund_d     = in_hund;
      rem_d      = in_rem[6:0];
      idx_d      = '0;
    end else if (run_end) begin
      hold_vld_d = 1'b0;
    end else if (advance) begin
      idx_d = idx_q + 4'd1;
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    if (advance) begin
      out_vld_d  = 1'b1;
      out_char_d = cur_char;
      out_last_d = cur_last;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    value_q    <= value_d;
    thou_q     <= thou_d;
    hund_q     <= hund_d;
    rem_q      <= rem_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- sv/avaf_checker.sv -----
`include "adc_value_ascii_formatter_defines.svh"

module avaf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [1:0] s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic       is_space;
  logic       is_digit;
  logic       is_hex_alpha;
  logic       out_stall;
  logic [9:0] out_word;
  logic       s_take;
  logic       out_empty_busy;

  assign is_space     = (m_axis_tdata_o == {1'b0, avaf_pkg::ASCII_SPACE});
  assign is_digit     = (m_axis_tdata_o >= {1'b0, avaf_pkg::ASCII_ZERO}) &&
                        (m_axis_tdata_o <= {1'b0, avaf_pkg::ASCII_NINE});
  assign is_hex_alpha = (m_axis_tdata_o >= {1'b0, avaf_pkg::ASCII_ALPHA_A}) &&
                        (m_axis_tdata_o <= {1'b0, avaf_pkg::ASCII_ALPHA_F});

  assign out_stall      = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word       = {m_axis_tvalid_o, m_axis_tlast_o, m_axis_tdata_o};
  // a value with text keeps the input busy while its run is spelled out
  assign s_take         = s_axis_tvalid_i && s_axis_tready_o &&
                          (s_axis_tuser_i != avaf_pkg::OP_NONE);
  // input blocked while the output register is empty
  assign out_empty_busy = !m_axis_tvalid_o && !s_axis_tready_o;

  // a stalled item keeps its data
  `AVAF_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_word), "stalled item changed")

  // every run ends on a space
  `AVAF_ASSERT_NOW(a_last_space, m_axis_tvalid_o && m_axis_tlast_o, is_space, "run end not a space")

  // only digits, A to F or space ever leave
  `AVAF_ASSERT_NOW(a_charset, m_axis_tvalid_o, is_space || is_digit || is_hex_alpha, "bad character")

  // a value with text is never followed by an accept in the next cycle
  `AVAF_ASSERT_NEXT(a_take_busy, s_take, !s_axis_tready_o, "input ready right after a value")

  // a held value moves into an empty output register at once
  `AVAF_ASSERT_NEXT(a_fill, out_empty_busy, m_axis_tvalid_o, "held value did not move out")

endmodule

bind adc_value_ascii_formatter avaf_checker u_avaf_checker (.*);
